>>> sv/lwbc_pkg.sv
// ----------------------------------------------------------------------------
// lwbc_pkg
// Shared types and codes of the LRU write-back block cache tag engine.
// ----------------------------------------------------------------------------
package lwbc_pkg;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_FSYNC = 2'd2,
    CMD_CLOSE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_HIT       = 2'd0,
    KIND_MISS      = 2'd1,
    KIND_WRITEBACK = 2'd2,
    KIND_DONE      = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [9:0]  file_id;
    logic [31:0] block_number;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [9:0]  out_file_id;
    logic [31:0] out_block_number;
    logic [3:0]  slot;
    logic        last;
  } rsp_t;

endpackage

>>> sv/lwbc_front.sv
// ----------------------------------------------------------------------------
// lwbc_front
// Request intake: a two-entry queue that holds accepted request beats
// until the tag engine takes them.
// ----------------------------------------------------------------------------
module lwbc_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid,
  output logic            in_ready,
  input  lwbc_pkg::req_t  in_data_i,
  output logic            q_valid_o,
  input  logic            q_pop_i,
  output lwbc_pkg::req_t  q_data_o
);

  lwbc_pkg::req_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready  = (cnt_q != 2'd2);
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o  = mem_q[rd_ptr_q];
  assign push      = in_valid && in_ready;
  assign pop       = q_pop_i && q_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= in_data_i;
  end

endmodule

>>> sv/lwbc_back.sv
// ----------------------------------------------------------------------------
// lwbc_back
// Tag engine: parallel lookup, LRU ranking, eviction, and the slot walk
// for fsync and close.
// ----------------------------------------------------------------------------
module lwbc_back #(
  parameter int SLOTS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [4:0]      cap_i,
  input  logic            q_valid_i,
  output logic            q_pop_o,
  input  lwbc_pkg::req_t  q_data_i,
  output logic            out_valid,
  input  logic            out_ready,
  output lwbc_pkg::rsp_t  out_data_o
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOOK, ST_EVICT, ST_ALLOC, ST_WALK, ST_DONE
  } state_e;

  state_e state_q;
  lwbc_pkg::req_t req_q;
  logic [SLOTS-1:0] valid_q, dirty_q;
  logic [9:0]  file_q  [SLOTS];
  logic [31:0] block_q [SLOTS];
  logic [IW-1:0] rank_q [SLOTS];

  logic [SLOTS-1:0] hit_vec, fmatch_vec;
  logic             hit_q;
  logic [IW-1:0]    hit_idx_q, idx_q;
  logic [CW-1:0]    count_q, cap_eff;
  logic             out_full_q;
  lwbc_pkg::rsp_t   out_q;
  logic             can_emit;

  assign out_valid  = out_full_q;
  assign out_data_o = out_q;
  assign can_emit   = !out_full_q || out_ready;
  assign q_pop_o    = (state_q == ST_IDLE) && q_valid_i;

  always_comb begin
    if (cap_i == 5'd0) cap_eff = CW'(1);
    else if (32'(cap_i) > SLOTS) cap_eff = CW'(SLOTS);
    else cap_eff = CW'(cap_i);
  end

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      fmatch_vec[i] = valid_q[i] && (file_q[i] == req_q.file_id);
      hit_vec[i]    = fmatch_vec[i] && (block_q[i] == req_q.block_number);
    end
  end

  logic [IW-1:0] hit_enc, free_idx, victim_idx;
  logic          victim_found;
  always_comb begin
    hit_enc = '0;
    free_idx = '0;
    victim_idx = '0;
    victim_found = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (hit_vec[i]) hit_enc = IW'(i);
      if (!valid_q[i]) free_idx = IW'(i);
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (valid_q[i] && ({1'b0, rank_q[i]} == (IW+1)'(count_q - CW'(1)))) begin
        victim_idx = IW'(i);
        victim_found = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      req_q      <= '0;
      valid_q    <= '0;
      dirty_q    <= '0;
      count_q    <= '0;
      out_full_q <= 1'b0;
      out_q      <= '0;
      hit_q      <= 1'b0;
      hit_idx_q  <= '0;
      idx_q      <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        file_q[i]  <= '0;
        block_q[i] <= '0;
        rank_q[i]  <= '0;
      end
    end else begin
      if (out_full_q && out_ready) out_full_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            req_q   <= q_data_i;
            idx_q   <= '0;
            state_q <= (q_data_i.command == lwbc_pkg::CMD_FSYNC ||
                        q_data_i.command == lwbc_pkg::CMD_CLOSE) ? ST_WALK : ST_LOOK;
          end
        end
        ST_LOOK: begin
          hit_q     <= |hit_vec;
          hit_idx_q <= hit_enc;
          if (|hit_vec) state_q <= ST_ALLOC;
          else if (count_q >= cap_eff && count_q != '0 && victim_found) begin
            idx_q   <= victim_idx;
            state_q <= ST_EVICT;
          end else state_q <= ST_ALLOC;
        end
        ST_EVICT: begin
          if (!dirty_q[idx_q] || can_emit) begin
            if (dirty_q[idx_q]) begin
              out_q      <= '{lwbc_pkg::KIND_WRITEBACK, file_q[idx_q], block_q[idx_q],
                              4'(idx_q), 1'b0};
              out_full_q <= 1'b1;
            end
            valid_q[idx_q] <= 1'b0;
            dirty_q[idx_q] <= 1'b0;
            count_q <= count_q - CW'(1);
            for (int i = 0; i < SLOTS; i++)
              if (valid_q[i] && rank_q[i] > rank_q[idx_q]) rank_q[i] <= rank_q[i] - IW'(1);
            state_q <= ST_ALLOC;
          end
        end
        ST_ALLOC: begin
          if (can_emit) begin
            out_full_q <= 1'b1;
            if (hit_q) begin
              for (int i = 0; i < SLOTS; i++)
                if (valid_q[i] && rank_q[i] < rank_q[hit_idx_q]) rank_q[i] <= rank_q[i] + IW'(1);
              rank_q[hit_idx_q] <= '0;
              if (req_q.command == lwbc_pkg::CMD_WRITE) dirty_q[hit_idx_q] <= 1'b1;
              out_q <= '{lwbc_pkg::KIND_HIT, req_q.file_id, req_q.block_number,
                         4'(hit_idx_q), 1'b1};
            end else begin
              for (int i = 0; i < SLOTS; i++)
                if (valid_q[i]) rank_q[i] <= rank_q[i] + IW'(1);
              valid_q[free_idx] <= 1'b1;
              dirty_q[free_idx] <= (req_q.command == lwbc_pkg::CMD_WRITE);
              file_q[free_idx]  <= req_q.file_id;
              block_q[free_idx] <= req_q.block_number;
              rank_q[free_idx]  <= '0;
              count_q <= count_q + CW'(1);
              out_q <= '{lwbc_pkg::KIND_MISS, req_q.file_id, req_q.block_number,
                         4'(free_idx), 1'b1};
            end
            state_q <= ST_IDLE;
          end
        end
        ST_WALK: begin
          if (!(fmatch_vec[idx_q] && dirty_q[idx_q]) || can_emit) begin
            if (fmatch_vec[idx_q]) begin
              if (dirty_q[idx_q]) begin
                out_q      <= '{lwbc_pkg::KIND_WRITEBACK, file_q[idx_q], block_q[idx_q],
                                4'(idx_q), 1'b0};
                out_full_q <= 1'b1;
              end
              dirty_q[idx_q] <= 1'b0;
              if (req_q.command == lwbc_pkg::CMD_CLOSE) begin
                valid_q[idx_q] <= 1'b0;
                count_q <= count_q - CW'(1);
                for (int i = 0; i < SLOTS; i++)
                  if (valid_q[i] && rank_q[i] > rank_q[idx_q])
                    rank_q[i] <= rank_q[i] - IW'(1);
              end
            end
            if (idx_q == IW'(SLOTS - 1)) state_q <= ST_DONE;
            else idx_q <= idx_q + IW'(1);
          end
        end
        ST_DONE: begin
          if (can_emit) begin
            out_q      <= '{lwbc_pkg::KIND_DONE, req_q.file_id, 32'd0, 4'd0, 1'b1};
            out_full_q <= 1'b1;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> sv/lru_writeback_block_cache_tags_core.sv
// ----------------------------------------------------------------------------
// lru_writeback_block_cache_tags_core
// Tag and LRU policy engine of a fully associative write-back block cache.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  request  | in_valid / in_ready   | in_data_i  (lwbc_pkg::req_t)
//  result   | out_valid / out_ready | out_data_o (lwbc_pkg::rsp_t)
//  config   | cfg_we_i              | cfg_data_i (capacity in use)
// A hit occupies the engine through the dequeue, tag-compare and rank-update
// states, a miss also through an eviction state when the cache is at capacity;
// the result beat is registered in the rank-update state. Fsync and close walk
// every slot. Reset empties the cache at once. A full result register stalls
// the engine; the request queue keeps taking beats meanwhile until it holds
// two.
module lru_writeback_block_cache_tags_core #(
  parameter int SLOTS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid,
  output logic            in_ready,
  input  lwbc_pkg::req_t  in_data_i,
  output logic            out_valid,
  input  logic            out_ready,
  output lwbc_pkg::rsp_t  out_data_o,
  input  logic            cfg_we_i,
  input  logic [4:0]      cfg_data_i
);

  logic [4:0]     cap_q;
  logic           q_valid, q_pop;
  lwbc_pkg::req_t q_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cap_q <= 5'(SLOTS);
    else if (cfg_we_i) cap_q <= cfg_data_i;
  end

  lwbc_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_ready, .in_data_i,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_data_o(q_data)
  );

  lwbc_back #(.SLOTS(SLOTS)) u_back (
    .clk_i, .rst_ni, .cap_i(cap_q),
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_data_i(q_data),
    .out_valid, .out_ready, .out_data_o
  );

endmodule
